// ===== sv/bte_pkg.sv =====
// ----------------------------------------------------------------------------
// bte_pkg
// Types, codes and defaults shared by the beat timer event scheduler.
// ----------------------------------------------------------------------------
package bte_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int MAX_FIRES_DEF = 63;
   localparam logic [16:0] TICK_SPAN_RST = 17'd2731;
   localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      MODE_ABS_TIMEOUT  = 3'd0,
      MODE_REL_TIMEOUT  = 3'd1,
      MODE_SYNC_TIMEOUT = 3'd2,
      MODE_ABS_INTERVAL = 3'd3,
      MODE_REL_INTERVAL = 3'd4,
      MODE_SYNC_INTERVAL = 3'd5,
      MODE_CANCEL       = 3'd6,
      MODE_PROCESS      = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ASSIGNED = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_CANCEL   = 3'd2,
      KIND_FIRED    = 3'd3,
      KIND_DONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      WAKE_NONE  = 2'd0,
      WAKE_DUE   = 2'd1,
      WAKE_TICK  = 2'd2,
      WAKE_LATER = 2'd3
   } wake_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [31:0]        now_beat;
      logic [31:0]        time_value;
      logic [31:0]        period;
      logic [31:0]        sync_unit;
      logic signed [31:0] sync_offset;
      logic [3:0]         slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot_id;
      logic [31:0] fire_now;
      logic [31:0] fire_goal;
      logic [31:0] fire_period;
      logic [1:0]  wake;
      logic [31:0] next_due;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? ALL32 : s[31:0];
   endfunction

endpackage

// ===== sv/beat_timer_event_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// beat_timer_event_scheduler_core
// Slot table of timed events keyed by due beat, with a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (insert, cancel or process); it is taken
//   when req_valid is high and req_stall is low. req_stall is high whenever
//   the sequencer is busy with an item, so one item is worked at a time.
//   rsp_* returns result items from an output register; the sequencer holds
//   while rsp_stall is high, and the final item of a command has last set.
//   csr_we/csr_wdata write tick_span; write it only while the block is idle.
// Sequence:
//   cancel: result in the cycle after the item is taken; absolute/relative
//   insert: through S_INSERT. sync insert: the shared restoring divider runs
//   32 steps for now mod sync and 32 for offset mod sync, then S_SYNC1 to
//   S_SYNC3 and S_INSERT. process: each fire or freed cancel costs one scan
//   of all slots through the slot memory read port, then S_DECIDE and S_OUT.
// Reset: slot active and cancel bits clear, tick_span returns to 2731. The
//   due and period memories are not cleared; only active slots use them.
//   No clearing pass is needed, items are taken right after reset.
// ----------------------------------------------------------------------------
module beat_timer_event_scheduler_core
   import bte_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int MAX_FIRES = MAX_FIRES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
   localparam logic [5:0] MAX_FIRES_C = 6'(MAX_FIRES);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DIV    = 9'b000000010,
      S_SYNC1  = 9'b000000100,
      S_SYNC2  = 9'b000001000,
      S_SYNC3  = 9'b000010000,
      S_INSERT = 9'b000100000,
      S_SCAN   = 9'b001000000,
      S_DECIDE = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in, after_ff, after_in;

   // Registered command and configuration.
   req_type     req_ff, req_in;
   logic [16:0] tick_ff;
   logic [31:0] goal_ff, goal_in;
   logic [31:0] per_ff, per_in;

   // Slot status in flops; payload in memories.
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] cancel_ff, cancel_in;
   logic [31:0] due_mem [SLOTS];
   logic [31:0] per_mem [SLOTS];
   logic [31:0] rd_due_ff, rd_per_ff;
   logic        due_we, per_we;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [31:0] due_wd;

   // Scan pipeline and best candidate.
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             best_v_ff, best_v_in;
   logic [IDX_W-1:0] best_s_ff, best_s_in;
   logic [31:0]      best_due_ff, best_due_in, best_per_ff, best_per_in;
   logic [5:0]       fires_ff, fires_in;

   // Shared divider and sync arithmetic.
   logic        dsel_ff, dsel_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [31:0] drem_ff, drem_in, ddvd_ff, ddvd_in;
   logic [31:0] r_now_ff, r_now_in;
   logic [31:0] unit_eff;
   logic [32:0] trial;
   logic [31:0] off_abs;
   logic [33:0] grid_ff, grid_in, qu_ff, qu_in;
   logic [31:0] m_ff, m_in;
   logic signed [34:0] v1_ff, v1_in;
   logic [33:0] cand_ff, cand_in;
   logic [34:0] vsel;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [IDX_W-1:0] free_idx;
   logic             free_v;
   logic [32:0]      wake_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign unit_eff = (req_ff.sync_unit == 32'd0) ? 32'd1 : req_ff.sync_unit;
   assign trial    = {drem_ff, ddvd_ff[31]} - {1'b0, unit_eff};
   assign off_abs  = req_ff.sync_offset[31] ? (32'd0 - req_ff.sync_offset) : req_ff.sync_offset;
   assign wake_sum = {1'b0, req_ff.now_beat} + {16'd0, tick_ff};
   assign rd_addr  = cnt_ff[IDX_W-1:0];

   // Lowest free slot.
   always_comb begin
      free_v   = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_v   = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      vsel = (v1_ff > $signed({3'b0, req_ff.now_beat})) ? 35'(v1_ff) : {1'b0, cand_ff};
   end

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      req_in       = req_ff;
      goal_in      = goal_ff;
      per_in       = per_ff;
      active_in    = active_ff;
      cancel_in    = cancel_ff;
      cnt_in       = cnt_ff;
      best_v_in    = best_v_ff;
      best_s_in    = best_s_ff;
      best_due_in  = best_due_ff;
      best_per_in  = best_per_ff;
      fires_in     = fires_ff;
      dsel_in      = dsel_ff;
      dcnt_in      = dcnt_ff;
      drem_in      = drem_ff;
      ddvd_in      = ddvd_ff;
      r_now_in     = r_now_ff;
      grid_in      = grid_ff;
      qu_in        = qu_ff;
      m_in         = m_ff;
      v1_in        = v1_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rd_vld_in    = 1'b0;
      due_we       = 1'b0;
      per_we       = 1'b0;
      wr_addr      = free_idx;
      due_wd       = goal_ff;

      // Compare stage of the scan: strict less keeps ties on the lower slot.
      if (rd_vld_ff && active_ff[rd_idx_ff] && (!best_v_ff || rd_due_ff < best_due_ff)) begin
         best_v_in   = 1'b1;
         best_s_in   = rd_idx_ff;
         best_due_in = rd_due_ff;
         best_per_in = rd_per_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               per_in = 32'd0;
               unique case (mode_type'(req_data.mode))
                  MODE_ABS_TIMEOUT: begin
                     goal_in  = req_data.time_value;
                     state_in = S_INSERT;
                  end
                  MODE_REL_TIMEOUT: begin
                     goal_in  = sat_add(req_data.now_beat, req_data.time_value);
                     state_in = S_INSERT;
                  end
                  MODE_ABS_INTERVAL: begin
                     goal_in  = req_data.time_value;
                     per_in   = req_data.period;
                     state_in = S_INSERT;
                  end
                  MODE_REL_INTERVAL: begin
                     goal_in  = sat_add(req_data.now_beat, req_data.period);
                     per_in   = req_data.period;
                     state_in = S_INSERT;
                  end
                  MODE_SYNC_TIMEOUT, MODE_SYNC_INTERVAL: begin
                     if (req_data.mode == MODE_SYNC_INTERVAL) per_in = req_data.period;
                     dsel_in  = 1'b0;
                     dcnt_in  = '0;
                     drem_in  = '0;
                     ddvd_in  = req_data.now_beat;
                     state_in = S_DIV;
                  end
                  MODE_CANCEL: begin
                     // Ack any slot; mark only an active one in range.
                     if ({28'd0, req_data.slot} < SLOTS
                         && active_ff[req_data.slot[IDX_W-1:0]])
                        cancel_in[req_data.slot[IDX_W-1:0]] = 1'b1;
                     rsp_in.kind    = KIND_CANCEL;
                     rsp_in.slot_id = req_data.slot;
                     rsp_valid_in   = 1'b1;
                     after_in       = S_IDLE;
                     state_in       = S_OUT;
                  end
                  MODE_PROCESS: begin
                     fires_in  = '0;
                     cnt_in    = '0;
                     best_v_in = 1'b0;
                     state_in  = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            // One restoring step per cycle.
            if (!trial[32]) drem_in = trial[31:0];
            else drem_in = {drem_ff[30:0], ddvd_ff[31]};
            ddvd_in = {ddvd_ff[30:0], 1'b0};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               if (!dsel_ff) begin
                  r_now_in = drem_in;
                  dsel_in  = 1'b1;
                  drem_in  = '0;
                  ddvd_in  = off_abs;
               end else begin
                  state_in = S_SYNC1;
               end
            end
         end
         S_SYNC1: begin
            qu_in   = {2'b0, req_ff.now_beat} - {2'b0, r_now_ff};
            grid_in = {2'b0, req_ff.now_beat} - {2'b0, r_now_ff} + {2'b0, unit_eff};
            if (req_ff.sync_offset[31] && drem_ff != 32'd0) m_in = unit_eff - drem_ff;
            else m_in = drem_ff;
            state_in = S_SYNC2;
         end
         S_SYNC2: begin
            v1_in   = $signed({1'b0, grid_ff}) + 35'(req_ff.sync_offset);
            cand_in = (m_ff > r_now_ff) ? (qu_ff + {2'b0, m_ff}) : (grid_ff + {2'b0, m_ff});
            state_in = S_SYNC3;
         end
         S_SYNC3: begin
            goal_in  = (vsel[34:32] != 3'd0) ? ALL32 : vsel[31:0];
            state_in = S_INSERT;
         end
         S_INSERT: begin
            rsp_in = '0;
            rsp_in.last = 1'b1;
            if (free_v) begin
               due_we    = 1'b1;
               per_we    = 1'b1;
               active_in[free_idx] = 1'b1;
               cancel_in[free_idx] = 1'b0;
               rsp_in.kind    = KIND_ASSIGNED;
               rsp_in.slot_id = 4'(free_idx);
            end else begin
               rsp_in.kind = KIND_FULL;
            end
            rsp_valid_in = 1'b1;
            after_in     = S_IDLE;
            state_in     = S_OUT;
         end
         S_SCAN: begin
            if (cnt_ff < SLOTS_C) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_in = '0;
            cnt_in    = '0;
            best_v_in = 1'b0;
            if (best_v_ff && req_ff.now_beat >= best_due_ff && cancel_ff[best_s_ff]) begin
               // Free the cancelled event silently and look again.
               active_in[best_s_ff] = 1'b0;
               cancel_in[best_s_ff] = 1'b0;
               state_in = S_SCAN;
            end else if (best_v_ff && req_ff.now_beat >= best_due_ff
                         && fires_ff < MAX_FIRES_C) begin
               rsp_in.kind        = KIND_FIRED;
               rsp_in.slot_id     = 4'(best_s_ff);
               rsp_in.fire_now    = req_ff.now_beat;
               rsp_in.fire_goal   = best_due_ff;
               rsp_in.fire_period = best_per_ff;
               if (best_per_ff != 32'd0) begin
                  due_we  = 1'b1;
                  wr_addr = best_s_ff;
                  due_wd  = sat_add(best_due_ff, best_per_ff);
               end else begin
                  active_in[best_s_ff] = 1'b0;
               end
               fires_in     = fires_ff + 6'd1;
               rsp_valid_in = 1'b1;
               after_in     = S_SCAN;
               state_in     = S_OUT;
            end else begin
               rsp_in.kind = KIND_DONE;
               rsp_in.last = 1'b1;
               if (best_v_ff) begin
                  rsp_in.next_due = best_due_ff;
                  if (wake_sum < {1'b0, best_due_ff}) rsp_in.wake = WAKE_LATER;
                  else if (req_ff.now_beat >= best_due_ff) rsp_in.wake = WAKE_DUE;
                  else rsp_in.wake = WAKE_TICK;
               end else begin
                  rsp_in.wake = WAKE_NONE;
               end
               rsp_valid_in = 1'b1;
               after_in     = S_IDLE;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            // Hold the result until the receiver takes it.
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = after_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Slot payload memories with registered read.
   always_ff @(posedge clock) begin
      if (due_we) due_mem[wr_addr] <= due_wd;
      if (per_we) per_mem[wr_addr] <= per_ff;
      rd_due_ff <= due_mem[rd_addr];
      rd_per_ff <= per_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         active_ff    <= '0;
         cancel_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         tick_ff      <= TICK_SPAN_RST;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         active_ff    <= active_in;
         cancel_ff    <= cancel_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         if (csr_we) tick_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      goal_ff     <= goal_in;
      per_ff      <= per_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_addr;
      best_v_ff   <= best_v_in;
      best_s_ff   <= best_s_in;
      best_due_ff <= best_due_in;
      best_per_ff <= best_per_in;
      fires_ff    <= fires_in;
      dsel_ff     <= dsel_in;
      dcnt_ff     <= dcnt_in;
      drem_ff     <= drem_in;
      ddvd_ff     <= ddvd_in;
      r_now_ff    <= r_now_in;
      grid_ff     <= grid_in;
      qu_ff       <= qu_in;
      m_ff        <= m_in;
      v1_ff       <= v1_in;
      cand_ff     <= cand_in;
      rsp_ff      <= rsp_in;
   end

endmodule
